/* rtl/core/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

/* rtl/core/crhs_pkg.sv */
// types and constants of the current ramp and hold sequencer
`timescale 1ns / 1ps

package crhs_pkg;

	localparam int SETPOINT_W = 15;
	localparam int TIME_W     = 32;
	localparam int DAC_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_ABORT = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_UP   = 3'd1,
		PH_HOLD = 3'd2,
		PH_DOWN = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 2'd1;

	localparam logic [SETPOINT_W-1:0] STEP_UA  = 15'd10;
	localparam logic [SETPOINT_W-1:0] SP_MAX   = 15'd32767;
	localparam logic [SETPOINT_W-1:0] CLAMP_UA = 15'd19990;

	// code = floor(c * 32852 / 10000) = floor(floor(c * 8213 / 4) / 625)
	localparam logic [13:0] SCALE_NUM   = 14'd8213;
	// ceil(2^34 / 625), exact for dividends below 2^26
	localparam logic [24:0] RECIP_M     = 25'd27487791;
	localparam int          RECIP_SHIFT = 34;

	typedef struct packed {
		logic                  wr;
		logic [SETPOINT_W-1:0] setpoint;
		phase_t                phase;
	} crhs_step_t;

	typedef struct packed {
		logic                  dac_write;
		logic [DAC_W-1:0]      dac_code;
		logic [SETPOINT_W-1:0] setpoint_now;
		phase_t                phase;
		logic                  done_res;
	} crhs_res_t;

endpackage

/* rtl/core/crhs_cmd_if.sv */
// command channel: opcode and timestamp beats
`timescale 1ns / 1ps

interface crhs_cmd_if;
	import crhs_pkg::*;

	logic              valid;
	logic              ready;
	op_t               opcode;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output opcode, output now_ms, input ready);
	modport sink   (input valid, input opcode, input now_ms, output ready);
endinterface

/* rtl/core/crhs_res_if.sv */
// result channel: dac write, setpoint and phase beats
`timescale 1ns / 1ps

interface crhs_res_if;
	import crhs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  dac_write;
	logic [DAC_W-1:0]      dac_code;
	logic [SETPOINT_W-1:0] setpoint_now;
	phase_t                phase;
	logic                  done_res;

	modport source (output valid, output dac_write, output dac_code, output setpoint_now,
		output phase, output done_res, input ready);
	modport sink   (input valid, input dac_write, input dac_code, input setpoint_now,
		input phase, input done_res, output ready);
endinterface

/* rtl/core/crhs_cfg_if.sv */
// configuration write channel
`timescale 1ns / 1ps

interface crhs_cfg_if;
	import crhs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/current_ramp_hold_sequencer.sv */
// top level of the stimulation current ramp and hold sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Current ramp and hold sequencer. Each command beat on cmd (tick, start, abort, stop
// plus a millisecond timestamp) yields exactly one result beat on res carrying the dac
// write strobe, the 16-bit dac code, the new setpoint in microamps and the phase. The
// phase, setpoint and hold start time update in the cycle the command is taken, so a new
// command can be taken every cycle while res is not stalled; throughput is then one beat
// per clock. Each result passes through the input register, the clamp and first multiply,
// the reciprocal multiply and the saturation into the output register, and the four-deep
// pipeline keeps taking commands while a result waits on res.ready until all stages hold
// a beat. The dac code is floor(min(setpoint, 19990) * 32852 / 10000), saturated at
// 65535, and zero on beats that do not write the dac. target_current and hold_time_ms
// are written on cfg (index 0 and 1, other indexes ignored) and should only change while
// the block is idle; cfg is always ready.
module current_ramp_hold_sequencer (
	input  logic     clk,
	input  logic     arst_n,
	crhs_cmd_if.sink cmd,
	crhs_res_if.source res,
	crhs_cfg_if.sink cfg
);
	import crhs_pkg::*;

	logic [SETPOINT_W-1:0] target_current_q;
	logic [TIME_W-1:0]     hold_time_ms_q;

	logic       cmd_accept;
	crhs_step_t step;
	crhs_res_t  res_payload;

	// config registers, one write beat per cycle
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_current_q <= '0;
			hold_time_ms_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TARGET: target_current_q <= cfg.data[SETPOINT_W-1:0];
				CFG_HOLD:   hold_time_ms_q   <= cfg.data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cmd_accept = cmd.valid && cmd.ready;

	// phase machine, updated on each accepted command beat
	crhs_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (cmd_accept),
		.opcode         (cmd.opcode),
		.now_ms         (cmd.now_ms),
		.target_current (target_current_q),
		.hold_time_ms   (hold_time_ms_q),
		.step           (step)
	);

	// dac scaling and result buffering
	crhs_dac_pipe u_dac_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_step   (step),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_res   (res_payload)
	);

	assign res.dac_write    = res_payload.dac_write;
	assign res.dac_code     = res_payload.dac_code;
	assign res.setpoint_now = res_payload.setpoint_now;
	assign res.phase        = res_payload.phase;
	assign res.done_res     = res_payload.done_res;

	// no dac code without a dac write
	`ASSERT_IMPLY(a_code_needs_write, clk, arst_n, res.valid && !res.dac_write, res.dac_code == '0)
	// zero setpoint always scales to a zero code
	`ASSERT_IMPLY(a_zero_sp_zero_code, clk, arst_n, res.valid && (res.setpoint_now == '0), res.dac_code == '0)
	// completion is only reached by stepping down to the floor
	`ASSERT_IMPLY(a_done_at_floor, clk, arst_n, res.valid && res.done_res && res.dac_write, res.setpoint_now <= STEP_UA)
	// done flag tracks the complete phase
	`ASSERT_ALWAYS(a_done_flag, clk, arst_n, !res.valid || (res.done_res == (res.phase == PH_DONE)))
endmodule

/* rtl/core/crhs_ctrl.sv */
// sequencer state machine: phase, setpoint and hold timestamp
`timescale 1ns / 1ps

module crhs_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  crhs_pkg::op_t                   opcode,
	input  logic [crhs_pkg::TIME_W-1:0]     now_ms,
	input  logic [crhs_pkg::SETPOINT_W-1:0] target_current,
	input  logic [crhs_pkg::TIME_W-1:0]     hold_time_ms,
	output crhs_pkg::crhs_step_t            step
);
	import crhs_pkg::*;

	phase_t                phase_q, phase_d;
	logic [SETPOINT_W-1:0] setpoint_q, setpoint_d;
	logic [TIME_W-1:0]     hold_start_q, hold_start_d;

	logic [SETPOINT_W:0]   sp_sum;
	logic [SETPOINT_W-1:0] sp_up;
	logic [SETPOINT_W-1:0] sp_down;
	logic [TIME_W-1:0]     elapsed;

	// saturating step up and down
	assign sp_sum  = {1'b0, setpoint_q} + {1'b0, STEP_UA};
	assign sp_up   = sp_sum[SETPOINT_W] ? SP_MAX : sp_sum[SETPOINT_W-1:0];
	assign sp_down = (setpoint_q >= STEP_UA) ? setpoint_q - STEP_UA : '0;
	// wraps with the timestamp
	assign elapsed = now_ms - hold_start_q;

	always_comb begin
		phase_d      = phase_q;
		setpoint_d   = setpoint_q;
		hold_start_d = hold_start_q;
		case (opcode)
			OP_START: begin
				setpoint_d = '0;
				phase_d    = PH_UP;
			end
			OP_STOP: begin
				setpoint_d   = '0;
				phase_d      = PH_IDLE;
				hold_start_d = '0;
			end
			OP_ABORT: begin
				phase_d = PH_DOWN;
			end
			OP_TICK: begin
				case (phase_q)
					PH_IDLE, PH_UP: begin
						setpoint_d = sp_up;
						if (sp_up >= target_current) begin
							phase_d      = PH_HOLD;
							hold_start_d = now_ms;
						end
					end
					PH_HOLD: begin
						if (elapsed >= hold_time_ms) begin
							phase_d = PH_DOWN;
						end
					end
					PH_DOWN: begin
						setpoint_d = sp_down;
						if (sp_down <= STEP_UA) begin
							phase_d = PH_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		step.setpoint = setpoint_d;
		step.phase    = phase_d;
		case (opcode)
			OP_START, OP_STOP: step.wr = 1'b1;
			OP_TICK:           step.wr = (phase_q == PH_IDLE) || (phase_q == PH_UP) ||
			                             (phase_q == PH_DOWN);
			default:           step.wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			setpoint_q   <= '0;
			hold_start_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			setpoint_q   <= setpoint_d;
			hold_start_q <= hold_start_d;
		end
	end
endmodule

/* rtl/core/crhs_dac_pipe.sv */
// dac scaling pipeline: clamp, two multiplies, saturate, output register
`timescale 1ns / 1ps

module crhs_dac_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  crhs_pkg::crhs_step_t in_step,
	output logic                 out_valid,
	input  logic                 out_ready,
	output crhs_pkg::crhs_res_t  out_res
);
	import crhs_pkg::*;

	localparam int PROD_A_W = SETPOINT_W + 14;
	localparam int Y_W      = 26;
	localparam int PROD_B_W = Y_W + 25;
	localparam int Q_W      = PROD_B_W - RECIP_SHIFT;

	logic v_s1, v_s2, v_s3, out_v_q;
	logic load_s1, load_s2, load_s3, load_out;

	crhs_step_t step_s1, step_s2, step_s3;
	logic [Y_W-1:0] y_s2;
	logic [Q_W-1:0] q_s3;
	crhs_res_t      res_q;

	logic [SETPOINT_W-1:0] clamp;
	logic [PROD_A_W-1:0]   prod_a;
	logic [PROD_B_W-1:0]   prod_b;
	logic [DAC_W-1:0]      code_sat;

	// a stage loads when it is empty or its content moves on
	assign load_out = !out_v_q || out_ready;
	assign load_s3  = !v_s3 || load_out;
	assign load_s2  = !v_s2 || load_s3;
	assign load_s1  = !v_s1 || load_s2;
	assign in_ready = load_s1;

	assign clamp    = (step_s1.setpoint > CLAMP_UA) ? CLAMP_UA : step_s1.setpoint;
	assign prod_a   = PROD_A_W'(clamp) * PROD_A_W'(SCALE_NUM);
	assign prod_b   = PROD_B_W'(y_s2) * PROD_B_W'(RECIP_M);
	assign code_sat = q_s3[Q_W-1] ? '1 : q_s3[DAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load_s1)  v_s1    <= in_valid;
			if (load_s2)  v_s2    <= v_s1;
			if (load_s3)  v_s3    <= v_s2;
			if (load_out) out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			step_s1 <= in_step;
		end
		if (load_s2) begin
			step_s2 <= step_s1;
			y_s2    <= prod_a[Y_W+1:2];
		end
		if (load_s3) begin
			step_s3 <= step_s2;
			q_s3    <= prod_b[PROD_B_W-1:RECIP_SHIFT];
		end
		if (load_out) begin
			res_q.dac_write    <= step_s3.wr;
			res_q.dac_code     <= step_s3.wr ? code_sat : '0;
			res_q.setpoint_now <= step_s3.setpoint;
			res_q.phase        <= step_s3.phase;
			res_q.done_res     <= (step_s3.phase == PH_DONE);
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = res_q;
endmodule
